>>> sv/stepper_step_pulse_generator_assert.svh
// Assertion macros for the step pulse generator.
`ifndef STEPPER_STEP_PULSE_GENERATOR_ASSERT_SVH
`define STEPPER_STEP_PULSE_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSPG_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("step pulse generator check failed");

// The consequent must hold in the cycle after the antecedent.
`define SSPG_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("step pulse generator check failed");

`endif

>>> sv/sspg_pkg.sv
package sspg_pkg;

    localparam int unsigned COUNT_W = 32;
    localparam int unsigned SPR_W = 16;
    localparam int unsigned WAIT_W = 16;
    localparam int unsigned MODE_W = 4;
    localparam int unsigned MAP_W = 36;
    localparam int unsigned STEPS_W = 56;
    localparam int unsigned PROD_W = COUNT_W + SPR_W;
    localparam int unsigned CFG_DATA_W = 36;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [MODE_W-1:0] MAX_MODE = 4'd8;
    localparam logic [COUNT_W-1:0] RST_STEP_PERIOD = 32'd1;
    localparam logic [SPR_W-1:0] RST_STEPS_PER_REV = 16'd200;
    localparam logic [WAIT_W-1:0] RST_STANDBY_WAIT = 16'd100;

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_RUN_STEPS = 2'd1,
        OP_RUN_REVS  = 2'd2,
        OP_STOP      = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_MODE     = 3'd0,
        CFG_MODE_MAP      = 3'd1,
        CFG_STEP_PERIOD   = 3'd2,
        CFG_STEPS_PER_REV = 3'd3,
        CFG_STANDBY_WAIT  = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_STANDBY = 3'd0,
        PH_WAIT_SB = 3'd1,
        PH_WAIT_EN = 3'd2,
        PH_HIGH    = 3'd3,
        PH_LOW     = 3'd4,
        PH_DONE    = 3'd5
    } phase_t;

endpackage

>>> sv/stepper_step_pulse_generator.sv
// Step/direction pulse generator for a microstepping driver. Every input beat
// is a tick, a run by steps, a run by revolutions or a stop, and yields exactly
// one result beat with the pin levels and run flags after that input. The block
// takes one input beat per clock cycle while m_ready does not stall the result;
// a result beat is presented once its input beat has gone from the input
// register through the phase update and the 32 by 16 revolution multiply into
// the result register. Configuration writes through cfg_wr_en, cfg_index and
// cfg_wr_data land in the configuration registers and should only be made while no beat is in flight.
`include "stepper_step_pulse_generator_assert.svh"

module stepper_step_pulse_generator (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [sspg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sspg_pkg::CFG_DATA_W-1:0]     cfg_wr_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_op,
    input  logic [sspg_pkg::COUNT_W-1:0]        s_count,
    input  logic                                s_direction,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_standby_pin,
    output logic                                m_step_pin,
    output logic                                m_dir_pin,
    output logic                                m_mode_one_pin,
    output logic                                m_mode_two_pin,
    output logic                                m_running,
    output logic                                m_finished
);

    logic [sspg_pkg::MODE_W-1:0]   step_mode_reg;
    logic [sspg_pkg::MAP_W-1:0]    mode_map_reg;
    logic [sspg_pkg::COUNT_W-1:0]  step_period_reg;
    logic [sspg_pkg::SPR_W-1:0]    steps_per_rev_reg;
    logic [sspg_pkg::WAIT_W-1:0]   standby_wait_reg;

    logic                          in_valid_reg;
    logic                          in_valid_next;
    sspg_pkg::op_t                 in_op_reg;
    logic [sspg_pkg::COUNT_W-1:0]  in_count_reg;
    logic                          in_dir_reg;

    sspg_pkg::phase_t              phase_reg;
    sspg_pkg::phase_t              phase_next;
    logic [sspg_pkg::STEPS_W-1:0]  steps_left_reg;
    logic [sspg_pkg::STEPS_W-1:0]  steps_left_next;
    logic [sspg_pkg::COUNT_W-1:0]  tick_count_reg;
    logic [sspg_pkg::COUNT_W-1:0]  tick_count_next;
    logic                          held_dir_reg;
    logic                          held_dir_next;
    logic                          run_flag_reg;
    logic                          run_flag_next;
    logic                          fin_next;

    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic                          standby_pin_reg;
    logic                          standby_pin_next;
    logic                          step_pin_reg;
    logic                          step_pin_next;
    logic                          dir_pin_reg;
    logic                          dir_pin_next;
    logic                          mode_one_reg;
    logic                          mode_two_reg;
    logic                          running_reg;
    logic                          finished_reg;

    logic                          advance;
    logic                          proc;
    logic [sspg_pkg::MODE_W-1:0]   eff_mode;
    logic [3:0]                    pattern;
    logic [sspg_pkg::PROD_W-1:0]   rev_prod;
    logic [sspg_pkg::STEPS_W-1:0]  rev_steps;
    logic [sspg_pkg::STEPS_W-1:0]  run_steps;
    logic [sspg_pkg::COUNT_W-1:0]  tick_inc;
    logic [sspg_pkg::STEPS_W-1:0]  steps_dec;

    assign advance = !m_valid_reg || m_ready;
    assign proc    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    assign eff_mode  = (step_mode_reg > sspg_pkg::MAX_MODE) ? sspg_pkg::MAX_MODE
                                                             : step_mode_reg;
    assign pattern   = mode_map_reg[{eff_mode, 2'b00} +: 4];
    assign rev_prod  = in_count_reg * sspg_pkg::PROD_W'(steps_per_rev_reg);
    assign rev_steps = sspg_pkg::STEPS_W'(rev_prod) << eff_mode;
    assign run_steps = (in_op_reg == sspg_pkg::OP_RUN_REVS) ? rev_steps
                                                            : sspg_pkg::STEPS_W'(in_count_reg);
    assign tick_inc  = tick_count_reg + 1'b1;
    assign steps_dec = steps_left_reg - 1'b1;

    assign in_valid_next = (s_valid && s_ready) ? 1'b1 : (proc ? 1'b0 : in_valid_reg);
    assign m_valid_next  = proc ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_comb begin
        phase_next      = phase_reg;
        steps_left_next = steps_left_reg;
        tick_count_next = tick_count_reg;
        held_dir_next   = held_dir_reg;
        run_flag_next   = run_flag_reg;
        fin_next        = 1'b0;
        case (in_op_reg)
            sspg_pkg::OP_TICK: begin
                case (phase_reg)
                    sspg_pkg::PH_WAIT_SB, sspg_pkg::PH_WAIT_EN: begin
                        if (tick_inc >= sspg_pkg::COUNT_W'(standby_wait_reg)) begin
                            tick_count_next = '0;
                            if (steps_left_reg == '0) begin
                                phase_next    = sspg_pkg::PH_DONE;
                                run_flag_next = 1'b0;
                                fin_next      = 1'b1;
                            end else begin
                                phase_next = sspg_pkg::PH_HIGH;
                            end
                        end else begin
                            tick_count_next = tick_inc;
                        end
                    end
                    sspg_pkg::PH_HIGH: begin
                        if (tick_inc >= step_period_reg) begin
                            tick_count_next = '0;
                            phase_next      = sspg_pkg::PH_LOW;
                        end else begin
                            tick_count_next = tick_inc;
                        end
                    end
                    sspg_pkg::PH_LOW: begin
                        if (tick_inc >= step_period_reg) begin
                            tick_count_next = '0;
                            steps_left_next = steps_dec;
                            if (steps_dec == '0) begin
                                phase_next    = sspg_pkg::PH_DONE;
                                run_flag_next = 1'b0;
                                fin_next      = 1'b1;
                            end else begin
                                phase_next = sspg_pkg::PH_HIGH;
                            end
                        end else begin
                            tick_count_next = tick_inc;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            sspg_pkg::OP_RUN_STEPS, sspg_pkg::OP_RUN_REVS: begin
                if (!run_flag_reg) begin
                    run_flag_next   = 1'b1;
                    steps_left_next = run_steps;
                    held_dir_next   = in_dir_reg;
                    tick_count_next = '0;
                    phase_next      = (phase_reg == sspg_pkg::PH_DONE) ? sspg_pkg::PH_WAIT_EN
                                                                       : sspg_pkg::PH_WAIT_SB;
                    if (standby_wait_reg == '0) begin
                        if (run_steps == '0) begin
                            phase_next    = sspg_pkg::PH_DONE;
                            run_flag_next = 1'b0;
                            fin_next      = 1'b1;
                        end else begin
                            phase_next = sspg_pkg::PH_HIGH;
                        end
                    end
                end
            end
            default: begin
                phase_next      = sspg_pkg::PH_STANDBY;
                run_flag_next   = 1'b0;
                steps_left_next = '0;
                tick_count_next = '0;
            end
        endcase
    end

    always_comb begin
        case (phase_next)
            sspg_pkg::PH_STANDBY: begin
                standby_pin_next = 1'b0;
                step_pin_next    = pattern[3];
                dir_pin_next     = pattern[2];
            end
            sspg_pkg::PH_WAIT_SB: begin
                standby_pin_next = 1'b1;
                step_pin_next    = pattern[3];
                dir_pin_next     = pattern[2];
            end
            sspg_pkg::PH_HIGH: begin
                standby_pin_next = 1'b1;
                step_pin_next    = 1'b1;
                dir_pin_next     = held_dir_next;
            end
            default: begin
                standby_pin_next = 1'b1;
                step_pin_next    = 1'b0;
                dir_pin_next     = held_dir_next;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_mode_reg     <= '0;
            mode_map_reg      <= '0;
            step_period_reg   <= sspg_pkg::RST_STEP_PERIOD;
            steps_per_rev_reg <= sspg_pkg::RST_STEPS_PER_REV;
            standby_wait_reg  <= sspg_pkg::RST_STANDBY_WAIT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                sspg_pkg::CFG_STEP_MODE: begin
                    step_mode_reg <= cfg_wr_data[sspg_pkg::MODE_W-1:0];
                end
                sspg_pkg::CFG_MODE_MAP: begin
                    mode_map_reg <= cfg_wr_data[sspg_pkg::MAP_W-1:0];
                end
                sspg_pkg::CFG_STEP_PERIOD: begin
                    if (cfg_wr_data[sspg_pkg::COUNT_W-1:0] == '0) begin
                        step_period_reg <= sspg_pkg::RST_STEP_PERIOD;
                    end else begin
                        step_period_reg <= cfg_wr_data[sspg_pkg::COUNT_W-1:0];
                    end
                end
                sspg_pkg::CFG_STEPS_PER_REV: begin
                    steps_per_rev_reg <= cfg_wr_data[sspg_pkg::SPR_W-1:0];
                end
                sspg_pkg::CFG_STANDBY_WAIT: begin
                    standby_wait_reg <= cfg_wr_data[sspg_pkg::WAIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            phase_reg      <= sspg_pkg::PH_STANDBY;
            steps_left_reg <= '0;
            tick_count_reg <= '0;
            held_dir_reg   <= 1'b0;
            run_flag_reg   <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (proc) begin
                phase_reg      <= phase_next;
                steps_left_reg <= steps_left_next;
                tick_count_reg <= tick_count_next;
                held_dir_reg   <= held_dir_next;
                run_flag_reg   <= run_flag_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg    <= sspg_pkg::op_t'(s_op);
            in_count_reg <= s_count;
            in_dir_reg   <= s_direction;
        end
        if (proc) begin
            standby_pin_reg <= standby_pin_next;
            step_pin_reg    <= step_pin_next;
            dir_pin_reg     <= dir_pin_next;
            mode_one_reg    <= pattern[1];
            mode_two_reg    <= pattern[0];
            running_reg     <= run_flag_next;
            finished_reg    <= fin_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_standby_pin  = standby_pin_reg;
    assign m_step_pin     = step_pin_reg;
    assign m_dir_pin      = dir_pin_reg;
    assign m_mode_one_pin = mode_one_reg;
    assign m_mode_two_pin = mode_two_reg;
    assign m_running      = running_reg;
    assign m_finished     = finished_reg;

    `SSPG_ASSERT_NOW(a_running_enabled, aclk, aresetn, m_valid && m_running, m_standby_pin)
    `SSPG_ASSERT_NOW(a_finished_idle, aclk, aresetn, m_valid && m_finished,
        !m_running && m_standby_pin)
    `SSPG_ASSERT_NOW(a_standby_clear, aclk, aresetn, phase_reg == sspg_pkg::PH_STANDBY,
        !run_flag_reg && (steps_left_reg == '0))
    `SSPG_ASSERT_NOW(a_pulse_has_steps, aclk, aresetn,
        (phase_reg == sspg_pkg::PH_HIGH) || (phase_reg == sspg_pkg::PH_LOW),
        run_flag_reg && (steps_left_reg != '0))
    `SSPG_ASSERT_NEXT(a_stop_to_standby, aclk, aresetn,
        proc && (in_op_reg == sspg_pkg::OP_STOP),
        (phase_reg == sspg_pkg::PH_STANDBY) && m_valid && !m_running)

endmodule

>>> tb/stepper_step_pulse_generator_checker.sv
`timescale 1ns / 100ps

module stepper_step_pulse_generator_checker (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [sspg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sspg_pkg::CFG_DATA_W-1:0]     cfg_wr_data,

    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [1:0]                          s_op,
    input  logic [sspg_pkg::COUNT_W-1:0]        s_count,
    input  logic                                s_direction,

    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic                                m_standby_pin,
    input  logic                                m_step_pin,
    input  logic                                m_dir_pin,
    input  logic                                m_mode_one_pin,
    input  logic                                m_mode_two_pin,
    input  logic                                m_running,
    input  logic                                m_finished,

    output int                                  mismatches,
    output int                                  outstanding,
    output int                                  results_seen,
    output int                                  runs_completed
);
    import sspg_pkg::*;

    typedef struct packed {
        logic standby;
        logic step;
        logic dir;
        logic mode_one;
        logic mode_two;
        logic running;
        logic finished;
    } pins_t;

    logic [3:0]  mode_sel;
    logic [35:0] pin_map;
    logic [31:0] half_period;
    logic [15:0] revs_steps;
    logic [15:0] settle_ticks;

    phase_t      ph;
    logic [63:0] steps_rem;
    logic [31:0] tick_cnt;
    logic        hold_dir;
    logic        run_on;

    pins_t       pin_queue[$];
    int          err_total;
    int          seen_total;
    int          fin_total;

    function automatic logic [3:0] capped_mode();
        return (mode_sel > MAX_MODE) ? MAX_MODE : mode_sel;
    endfunction

    // The wait is over: either the first pulse starts or an empty run completes.
    function automatic logic begin_pulses();
        tick_cnt = '0;
        if (steps_rem == 0) begin
            ph = PH_DONE;
            run_on = 1'b0;
            return 1'b1;
        end
        ph = PH_HIGH;
        return 1'b0;
    endfunction

    function automatic logic advance_tick();
        case (ph)
            PH_WAIT_SB, PH_WAIT_EN: begin
                tick_cnt = tick_cnt + 1;
                if (tick_cnt >= {16'd0, settle_ticks})
                    return begin_pulses();
            end
            PH_HIGH: begin
                tick_cnt = tick_cnt + 1;
                if (tick_cnt >= half_period) begin
                    tick_cnt = '0;
                    ph = PH_LOW;
                end
            end
            PH_LOW: begin
                tick_cnt = tick_cnt + 1;
                if (tick_cnt >= half_period) begin
                    tick_cnt = '0;
                    steps_rem = steps_rem - 1;
                    if (steps_rem == 0) begin
                        ph = PH_DONE;
                        run_on = 1'b0;
                        return 1'b1;
                    end
                    ph = PH_HIGH;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic logic start_run(logic [63:0] steps, logic dir);
        if (run_on)
            return 1'b0;
        run_on = 1'b1;
        steps_rem = steps;
        hold_dir = dir;
        tick_cnt = '0;
        ph = (ph == PH_DONE) ? PH_WAIT_EN : PH_WAIT_SB;
        if (settle_ticks == 0)
            return begin_pulses();
        return 1'b0;
    endfunction

    function automatic pins_t next_pins(op_t op, logic [31:0] cnt, logic dir);
        logic        fin;
        logic [35:0] shifted;
        logic [3:0]  pat;
        pins_t       p;
        fin = 1'b0;
        case (op)
            OP_TICK:      fin = advance_tick();
            OP_RUN_STEPS: fin = start_run({32'd0, cnt}, dir);
            OP_RUN_REVS:  fin = start_run(({32'd0, cnt} * {48'd0, revs_steps}) << capped_mode(),
                                          dir);
            default: begin
                ph = PH_STANDBY;
                run_on = 1'b0;
                steps_rem = '0;
                tick_cnt = '0;
            end
        endcase
        shifted = pin_map >> (4 * capped_mode());
        pat = shifted[3:0];
        if (ph == PH_STANDBY || ph == PH_WAIT_SB) begin
            p.standby = (ph != PH_STANDBY);
            p.step = pat[3];
            p.dir = pat[2];
        end else begin
            p.standby = 1'b1;
            p.step = (ph == PH_HIGH);
            p.dir = hold_dir;
        end
        p.mode_one = pat[1];
        p.mode_two = pat[0];
        p.running = run_on;
        p.finished = fin;
        return p;
    endfunction

    function automatic int check_field(string name, logic want, logic got);
        if (want !== got) begin
            $error("%s: expected %0b, actual %0b", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin : monitor
        pins_t want;
        if (!aresetn) begin
            mode_sel = '0;
            pin_map = '0;
            half_period = RST_STEP_PERIOD;
            revs_steps = RST_STEPS_PER_REV;
            settle_ticks = RST_STANDBY_WAIT;
            ph = PH_STANDBY;
            steps_rem = '0;
            tick_cnt = '0;
            hold_dir = 1'b0;
            run_on = 1'b0;
            pin_queue.delete();
            err_total = 0;
            seen_total = 0;
            fin_total = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_STEP_MODE:     mode_sel = cfg_wr_data[3:0];
                    CFG_MODE_MAP:      pin_map = cfg_wr_data;
                    CFG_STEP_PERIOD:   half_period = (cfg_wr_data[31:0] == 0) ?
                                                     32'd1 : cfg_wr_data[31:0];
                    CFG_STEPS_PER_REV: revs_steps = cfg_wr_data[15:0];
                    CFG_STANDBY_WAIT:  settle_ticks = cfg_wr_data[15:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                seen_total++;
                if (pin_queue.size() == 0) begin
                    $error("result beat arrived with no prediction waiting");
                    err_total++;
                end else begin
                    want = pin_queue.pop_front();
                    err_total += check_field("standby_pin", want.standby, m_standby_pin);
                    err_total += check_field("step_pin", want.step, m_step_pin);
                    err_total += check_field("dir_pin", want.dir, m_dir_pin);
                    err_total += check_field("mode_one_pin", want.mode_one, m_mode_one_pin);
                    err_total += check_field("mode_two_pin", want.mode_two, m_mode_two_pin);
                    err_total += check_field("running", want.running, m_running);
                    err_total += check_field("finished", want.finished, m_finished);
                    if (want.finished)
                        fin_total++;
                end
            end
            if (s_valid && s_ready)
                pin_queue.push_back(next_pins(op_t'(s_op), s_count, s_direction));
        end
        mismatches <= err_total;
        outstanding <= pin_queue.size();
        results_seen <= seen_total;
        runs_completed <= fin_total;
    end

endmodule

>>> tb/tb_stepper_step_pulse_generator.sv
`timescale 1ns / 100ps

module tb_stepper_step_pulse_generator;
    import sspg_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES = 9;
    localparam int BEATS_PER_PHASE = 100;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_op = OP_TICK;
    logic [COUNT_W-1:0]    s_count = '0;
    logic                  s_direction = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_standby_pin;
    logic                  m_step_pin;
    logic                  m_dir_pin;
    logic                  m_mode_one_pin;
    logic                  m_mode_two_pin;
    logic                  m_running;
    logic                  m_finished;

    int mismatches;
    int outstanding;
    int results_seen;
    int runs_completed;
    int cycles = 0;
    int beats_sent = 0;
    int burst_left = 0;
    bit idle_on = 1'b0;

    stepper_step_pulse_generator uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_count        (s_count),
        .s_direction    (s_direction),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_standby_pin  (m_standby_pin),
        .m_step_pin     (m_step_pin),
        .m_dir_pin      (m_dir_pin),
        .m_mode_one_pin (m_mode_one_pin),
        .m_mode_two_pin (m_mode_two_pin),
        .m_running      (m_running),
        .m_finished     (m_finished)
    );

    stepper_step_pulse_generator_checker pin_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_count        (s_count),
        .s_direction    (s_direction),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_standby_pin  (m_standby_pin),
        .m_step_pin     (m_step_pin),
        .m_dir_pin      (m_dir_pin),
        .m_mode_one_pin (m_mode_one_pin),
        .m_mode_two_pin (m_mode_two_pin),
        .m_running      (m_running),
        .m_finished     (m_finished),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .results_seen   (results_seen),
        .runs_completed (runs_completed)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("stepper_step_pulse_generator: mismatch");
        $finish;
    end

    // The receiver stalls on its own schedule: open, random, or a rotating mask.
    initial begin : result_stall
        int       stall_left;
        int       stall_kind;
        logic [7:0] stall_mask;
        stall_left = 0;
        stall_kind = 0;
        stall_mask = 8'hff;
        forever begin
            @(posedge aclk);
            if (stall_left == 0) begin
                stall_kind = $urandom_range(0, 2);
                stall_left = $urandom_range(20, 80);
                stall_mask = 8'($urandom) | 8'h01;
            end
            stall_left--;
            case (stall_kind)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= stall_mask[stall_left % 8];
            endcase
        end
    end

    task automatic send_beat(input op_t op, input logic [31:0] cnt, input logic dir);
        int gap;
        if (burst_left == 0) begin
            gap = idle_on ? $urandom_range(1, 6) : 0;
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_op <= op;
        s_count <= cnt;
        s_direction <= dir;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
    endtask

    // Upper bits beyond each register's width carry junk that must be dropped.
    task automatic set_regs(input logic [3:0] mode, input logic [35:0] map,
                            input logic [31:0] period, input logic [15:0] spr,
                            input logic [15:0] settle);
        logic [35:0] junk;
        junk = 36'({$urandom, $urandom});
        put_reg(CFG_STEP_MODE, {junk[35:4], mode});
        put_reg(CFG_MODE_MAP, map);
        put_reg(CFG_STEP_PERIOD, {junk[35:32], period});
        put_reg(CFG_STEPS_PER_REV, {junk[35:16], spr});
        put_reg(CFG_STANDBY_WAIT, {junk[19:0], settle});
        put_reg(CFG_SPARE_IDX, 36'({$urandom, $urandom}));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_beat();
        int          pick;
        logic [31:0] cnt;
        logic        dir;
        pick = $urandom_range(0, 99);
        cnt = $urandom;
        dir = 1'($urandom_range(0, 1));
        if (pick < 72) begin
            send_beat(OP_TICK, cnt, dir);
        end else if (pick < 84) begin
            if ($urandom_range(0, 9) != 0)
                cnt = $urandom_range(0, 4);
            send_beat(OP_RUN_STEPS, cnt, dir);
        end else if (pick < 92) begin
            if ($urandom_range(0, 9) != 0)
                cnt = $urandom_range(0, 2);
            send_beat(OP_RUN_REVS, cnt, dir);
        end else if (pick < 96) begin
            send_beat(OP_STOP, cnt, dir);
        end else begin
            send_beat(OP_TICK, cnt, dir);
        end
    endtask

    initial begin : stimulus
        int          ph_i;
        logic [35:0] rand_map;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: idle tick and stop, a long run, an ignored run, then a stop.
        send_beat(OP_TICK, 32'h0, 1'b0);
        send_beat(OP_STOP, 32'hffff_ffff, 1'b1);
        send_beat(OP_RUN_STEPS, 32'hffff_ffff, 1'b1);
        send_beat(OP_RUN_REVS, 32'hffff_ffff, 1'b0);
        send_beat(OP_TICK, 32'h5555_5555, 1'b1);
        send_beat(OP_TICK, 32'haaaa_aaaa, 1'b0);
        send_beat(OP_STOP, 32'h0, 1'b0);
        drain();

        // Mode index above eight, zero period, zero wait.
        set_regs(4'hf, 36'h5_a5a5_a5a5, 32'h0, 16'd1, 16'd0);
        send_beat(OP_RUN_STEPS, 32'h0, 1'b1);
        send_beat(OP_RUN_STEPS, 32'h2, 1'b0);
        repeat (4) send_beat(OP_TICK, 32'h0, 1'b0);
        send_beat(OP_RUN_REVS, 32'h1, 1'b1);
        send_beat(OP_TICK, 32'h0, 1'b0);
        send_beat(OP_STOP, 32'h0, 1'b0);
        send_beat(OP_TICK, 32'h0, 1'b1);
        drain();

        set_regs(4'h8, 36'hf_ffff_ffff, 32'hffff_ffff, 16'hffff, 16'd1);
        send_beat(OP_RUN_STEPS, 32'h0, 1'b0);
        send_beat(OP_TICK, 32'h0, 1'b0);
        send_beat(OP_RUN_REVS, 32'hffff_ffff, 1'b1);
        send_beat(OP_TICK, 32'h0, 1'b1);
        send_beat(OP_TICK, 32'h0, 1'b0);
        send_beat(OP_STOP, 32'h0, 1'b1);
        drain();

        for (ph_i = 0; ph_i < PHASES; ph_i++) begin
            rand_map = 36'({$urandom, $urandom});
            case (ph_i)
                0: set_regs(4'd0, rand_map, 32'd1, 16'd1, 16'd0);
                1: set_regs(4'd1, rand_map, 32'd2, 16'd2, 16'd1);
                2: set_regs(4'd8, 36'hf_ffff_ffff, 32'd1, 16'd1, 16'd3);
                3: set_regs(4'hf, 36'h0, 32'd0, 16'd1, 16'd2);
                4: set_regs(4'd2, rand_map, 32'd3, 16'd3, 16'd0);
                5: set_regs(4'($urandom_range(0, 3)), rand_map, 32'hffff_ffff, 16'hffff,
                            16'hffff);
                6: set_regs(4'd0, rand_map, 32'd1, 16'd1, 16'd1);
                default: set_regs(4'($urandom_range(0, 15)), rand_map, $urandom_range(1, 4),
                                  16'($urandom_range(1, 4)), 16'($urandom_range(0, 4)));
            endcase
            idle_on = (ph_i % 3 != 0);
            repeat (BEATS_PER_PHASE) begin
                random_beat();
                if ($urandom_range(0, 49) == 0)
                    drain();
            end
            drain();
        end

        repeat (20) @(posedge aclk);
        $display("Sent %0d input beats over %0d register settings, checked %0d results,",
                 beats_sent, PHASES + 3, results_seen);
        $display("and saw %0d runs complete.", runs_completed);
        if (mismatches == 0 && outstanding == 0) begin
            $display("stepper_step_pulse_generator: match");
        end else begin
            $display("stepper_step_pulse_generator: mismatch");
        end
        $finish;
    end

endmodule
